### rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants, register indexes and elaboration-time curve helpers for
// the exponential soft clip distortion block.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  // defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int CURVE_ENTRIES_DEF = 256;

  // register widths and reset values
  localparam int GAIN_W = 16;
  localparam int WET_W = 17;
  localparam int CFG_DATA_W = 17;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1280;
  localparam logic [WET_W-1:0] WET_RESET = 17'd32768;
  localparam logic [WET_W-1:0] WET_FULL = 17'd65536;

  // interpolation fraction bits
  localparam int FRAC_BITS = 16;

  // register indexes
  typedef enum logic [0:0] {
    REG_DRIVE_GAIN   = 1'b0,
    REG_WET_FRACTION = 1'b1
  } reg_index_t;

  // shift-subtract divide, used only while building constants
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] rem;
    q = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      if (rem >= d) begin
        rem = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-h) in Q0.32 from a series up to the 24th power, h given in Q0.32
  function automatic logic [63:0] exp_ratio(input logic [63:0] hq);
    logic [63:0] term;
    logic [63:0] r;
    term = 64'd1 << 32;
    r = 64'd1 << 32;
    for (int n = 1; n <= 24; n++) begin
      term = udiv64((term * hq) >> 32, 64'(n));
      if ((n % 2) == 1) r = r - term;
      else r = r + term;
    end
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    return r;
  endfunction

  // curve point k: 1 - exp(-k*h) in Q0.(s-1)
  function automatic logic [63:0] curve_entry(input int k, input logic [63:0] r, input int s);
    logic [63:0] e;
    logic [63:0] t;
    e = 64'd1 << 32;
    t = '0;
    for (int j = 1; j <= k; j++) begin
      e = (e * r + (64'd1 << 31)) >> 32;
    end
    if (k != 0) begin
      t = ((64'd1 << 32) - e + (64'd1 << (32 - s))) >> (33 - s);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

### rtl/esc_gain.sv
// ----------------------------------------------------------------------------
// esc_gain
// Two pipeline stages: magnitude of the sample, then scaling by the drive
// gain.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_gain
  import esc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [SAMPLE_BITS-1:0] in_x,
  input  wire                          in_last,
  input  wire         [GAIN_W-1:0]      drive_gain,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_x,
  output logic                         out_last,
  output logic [SAMPLE_BITS+GAIN_W-1:0] out_qm
);

  localparam int S = SAMPLE_BITS;

  logic v1, v2;
  logic rdy1, rdy2;

  logic signed [S-1:0] x1;
  logic            last1;
  logic [S-1:0]    ax1;
  logic [S-1:0]    ax_next;

  // stage handshake, a stage loads when empty or draining
  assign rdy2 = !v2 || out_ready;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  // magnitude, the most negative sample fits as unsigned
  assign ax_next = in_x[S-1] ? (~in_x + 1'b1) : in_x;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      x1 <= in_x;
      last1 <= in_last;
      ax1 <= ax_next;
    end
  end

  // gain product, units of 2^-(S+7)
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      out_x <= x1;
      out_last <= last1;
      out_qm <= ax1 * drive_gain;
    end
  end

endmodule

`default_nettype wire

### rtl/esc_curve.sv
// ----------------------------------------------------------------------------
// esc_curve
// Three pipeline stages: table position, curve table lookup, and linear
// interpolation giving the signed clipped value.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_curve
  import esc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int CURVE_TABLE_ENTRIES = CURVE_ENTRIES_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  signed [SAMPLE_BITS-1:0]  in_x,
  input  wire                           in_last,
  input  wire  [SAMPLE_BITS+GAIN_W-1:0]  in_qm,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]  out_x,
  output logic                          out_last,
  output logic signed [SAMPLE_BITS:0]    out_z
);

  localparam int S = SAMPLE_BITS;
  localparam int N = CURVE_TABLE_ENTRIES;
  localparam int RANGE_SHIFT = S + 11;
  localparam int IDX_W = $clog2(N + 1);
  localparam int POS_W = RANGE_SHIFT + IDX_W;
  localparam logic [63:0] HQ = (64'd16 << 32) / N;
  localparam logic [63:0] RATIO = exp_ratio(HQ);
  localparam logic [S-1:0] FULL_SCALE = S'(1) << (S - 1);

  // constant curve table, N+1 points
  logic [S-1:0] curve_rom [0:N];

  for (genvar k = 0; k <= N; k++) begin : g_rom
    localparam logic [63:0] POINT = curve_entry(k, RATIO, S);
    assign curve_rom[k] = POINT[S-1:0];
  end

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // stage 1 registers
  logic signed [S-1:0] x1;
  logic            last1;
  logic            over1;
  logic [POS_W-1:0] pos1;

  // stage 2 registers
  logic signed [S-1:0] x2;
  logic            last2;
  logic            over2;
  logic [S-1:0]    lo2;
  logic [S-1:0]    diff2;
  logic [FRAC_BITS-1:0] fr2;

  // lookup and interpolation terms
  logic [IDX_W-1:0] idx_lo;
  logic [IDX_W-1:0] idx_hi;
  logic [S-1:0]     rom_lo;
  logic [S-1:0]     rom_hi;
  logic [S+FRAC_BITS-1:0] prod;
  logic [S+FRAC_BITS:0]   prod_rnd;
  logic [S:0]       mag_sum;
  logic [S-1:0]     mag;
  logic signed [S:0] z_next;

  // stage handshake
  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // table position, anything at or past the table end is full scale
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      x1 <= in_x;
      last1 <= in_last;
      over1 <= |in_qm[S+GAIN_W-1:RANGE_SHIFT];
      pos1 <= POS_W'(in_qm[RANGE_SHIFT-1:0]) * POS_W'(N);
    end
  end

  // table lookup at idx and idx+1
  assign idx_lo = pos1[POS_W-1:RANGE_SHIFT];
  assign idx_hi = idx_lo + 1'b1;
  assign rom_lo = curve_rom[idx_lo];
  assign rom_hi = curve_rom[idx_hi];

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      x2 <= x1;
      last2 <= last1;
      over2 <= over1;
      lo2 <= rom_lo;
      diff2 <= (rom_hi > rom_lo) ? (rom_hi - rom_lo) : '0;
      fr2 <= pos1[RANGE_SHIFT-1 -: FRAC_BITS];
    end
  end

  // rounded interpolation and sign
  assign prod = diff2 * fr2;
  assign prod_rnd = {1'b0, prod} + (S + FRAC_BITS + 1)'(1 << (FRAC_BITS - 1));
  assign mag_sum = {1'b0, lo2} + prod_rnd[S+FRAC_BITS:FRAC_BITS];
  assign mag = over2 ? FULL_SCALE : mag_sum[S-1:0];
  assign z_next = x2[S-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      out_x <= x2;
      out_last <= last2;
      out_z <= z_next;
    end
  end

endmodule

`default_nettype wire

### rtl/esc_mix.sv
// ----------------------------------------------------------------------------
// esc_mix
// Two pipeline stages: wet and dry products, then rounded sum with
// saturation to the sample range.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_mix
  import esc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  signed [SAMPLE_BITS-1:0]  in_x,
  input  wire                           in_last,
  input  wire  signed [SAMPLE_BITS:0]    in_z,
  input  wire  [WET_W-1:0]               wet_fraction,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]  out_y,
  output logic                          out_last
);

  localparam int S = SAMPLE_BITS;
  localparam int PW_W = S + 19;
  localparam int PD_W = S + 18;
  localparam int ACC_W = S + 20;
  localparam int Y_W = ACC_W - 16;
  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((64'd1 << (S - 1)) - 64'd1);
  localparam logic signed [Y_W-1:0] Y_MIN = -Y_W'(64'd1 << (S - 1));
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  logic v1, v2;
  logic rdy1, rdy2;

  logic [WET_W-1:0] wet_cl;
  logic [WET_W-1:0] dry_w;

  logic signed [PW_W-1:0] pw1;
  logic signed [PD_W-1:0] pd1;
  logic            last1;

  logic signed [ACC_W-1:0] acc;
  logic signed [Y_W-1:0]   y_full;

  // stage handshake
  assign rdy2 = !v2 || out_ready;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  // wet fraction saturates at fully wet
  assign wet_cl = (wet_fraction > WET_FULL) ? WET_FULL : wet_fraction;
  assign dry_w = WET_FULL - wet_cl;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      pw1 <= $signed({1'b0, wet_cl}) * in_z;
      pd1 <= $signed({1'b0, dry_w}) * in_x;
      last1 <= in_last;
    end
  end

  // rounded sum, floor shift, clamp
  assign acc = {{(ACC_W-PW_W){pw1[PW_W-1]}}, pw1}
             + {{(ACC_W-PD_W){pd1[PD_W-1]}}, pd1}
             + ROUND_HALF;
  assign y_full = acc[ACC_W-1:16];

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      out_last <= last1;
      if (y_full > Y_MAX) out_y <= Y_MAX[S-1:0];
      else if (y_full < Y_MIN) out_y <= Y_MIN[S-1:0];
      else out_y <= y_full[S-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/exponential_soft_clip_distortion.sv
// ----------------------------------------------------------------------------
// exponential_soft_clip_distortion
// Exponential soft clipping with dry/wet blend on a sample stream.
// ----------------------------------------------------------------------------
// One sample enters per clock while the output is not stalled; the seven
// register stages are magnitude, gain multiply, table position, curve table
// lookup, interpolation multiply, wet/dry products, and rounded sum with
// saturation. Each stage holds its beat only while the stage after it is
// full and stalled, so gaps in the stream are taken up and the input keeps
// accepting while a result waits, until all seven stages hold a beat.
// The curve table is constant and built at elaboration, so the block is
// ready straight out of reset. Write drive_gain and wet_fraction only while
// no beat is in flight; they are read live by the pipeline.
`default_nettype none

module exponential_soft_clip_distortion
  import esc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int CURVE_TABLE_ENTRIES = CURVE_ENTRIES_DEF,
  parameter int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire                  clk,
  input  wire                  rst,
  // input stream
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire  [TDATA_W-1:0]   s_tdata,   // sample_in
  input  wire                  s_tlast,   // block_end
  // output stream
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [TDATA_W-1:0]   m_tdata,   // sample_out
  output logic                 m_tlast,   // block_end_out
  // configuration writes
  input  wire                  cfg_we,
  input  wire  [0:0]           cfg_addr,
  input  wire  [CFG_DATA_W-1:0] cfg_data
);

  localparam int S = SAMPLE_BITS;

  logic [GAIN_W-1:0] drive_gain;
  logic [WET_W-1:0]  wet_fraction;

  logic                 g_valid, g_ready;
  logic signed [S-1:0]  g_x;
  logic                 g_last;
  logic [S+GAIN_W-1:0]  g_qm;

  logic                 c_valid, c_ready;
  logic signed [S-1:0]  c_x;
  logic                 c_last;
  logic signed [S:0]    c_z;

  logic signed [S-1:0]  y;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain <= GAIN_RESET;
      wet_fraction <= WET_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_DRIVE_GAIN:   drive_gain <= cfg_data[GAIN_W-1:0];
        REG_WET_FRACTION: wet_fraction <= cfg_data[WET_W-1:0];
        default: ;
      endcase
    end
  end

  // magnitude and gain
  esc_gain #(
    .SAMPLE_BITS(S)
  ) u_gain (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      ($signed(s_tdata[S-1:0])),
    .in_last   (s_tlast),
    .drive_gain(drive_gain),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_x     (g_x),
    .out_last  (g_last),
    .out_qm    (g_qm)
  );

  // clipping curve
  esc_curve #(
    .SAMPLE_BITS(S),
    .CURVE_TABLE_ENTRIES(CURVE_TABLE_ENTRIES)
  ) u_curve (
    .clk      (clk),
    .rst      (rst),
    .in_valid (g_valid),
    .in_ready (g_ready),
    .in_x     (g_x),
    .in_last  (g_last),
    .in_qm    (g_qm),
    .out_valid(c_valid),
    .out_ready(c_ready),
    .out_x    (c_x),
    .out_last (c_last),
    .out_z    (c_z)
  );

  // dry/wet blend and saturation
  esc_mix #(
    .SAMPLE_BITS(S)
  ) u_mix (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (c_valid),
    .in_ready    (c_ready),
    .in_x        (c_x),
    .in_last     (c_last),
    .in_z        (c_z),
    .wet_fraction(wet_fraction),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_y       (y),
    .out_last    (m_tlast)
  );

  assign m_tdata = TDATA_W'($unsigned(y));

endmodule

`default_nettype wire

### rtl/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks on the distortion block, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_checker #(
  parameter int TDATA_W = 24
) (
  input wire               clk,
  input wire               rst,
  input wire               s_tready,
  input wire               m_tvalid,
  input wire               m_tready,
  input wire [TDATA_W-1:0] m_tdata,
  input wire               m_tlast
);

  // pipeline is empty after reset
  a_empty_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid right after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  // a draining output never blocks the input
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  // an empty output stage leaves room for a new beat
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no output beat pending");

endmodule

bind exponential_soft_clip_distortion esc_checker #(
  .TDATA_W(TDATA_W)
) u_esc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

`default_nettype wire
